// ===== rtl/hct_pkg.sv =====
// ============================================================================
// hct_pkg: shared types and constants for the HTML/CJK tokenizer
// Record and bundle layouts, token kind codes, byte constants, helpers.
// ============================================================================
package hct_pkg;

  // Width of byte counts inside the document (offsets wrap at this width)
  localparam int OFFSET_BITS  = 32;

  // Up to four records come out of one input byte
  localparam int MAX_RECS     = 4;
  localparam int REC_CNT_W    = $clog2(MAX_RECS + 1);
  localparam int REC_IDX_W    = $clog2(MAX_RECS);

  // Number of candidate records examined per byte (word, bigram, char, text, tag)
  localparam int NUM_SLOTS    = 5;

  // Queue of per-byte bundles between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Output stream layout
  localparam int KIND_W       = 3;
  localparam int OUT_FIELDS_W = KIND_W + 32 + 32;
  localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Document bytes with a meaning of their own
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;

  // Bits of the kind enable register
  localparam int EN_BIT_TAG  = 0;
  localparam int EN_BIT_TEXT = 1;
  localparam int EN_BIT_WORD = 2;
  localparam int EN_BIT_CJK  = 3;

  // Register select (address bit 2)
  localparam logic REG_BASE_OFFSET  = 1'b0;
  localparam logic REG_KIND_ENABLES = 1'b1;

  localparam logic [31:0] BASE_OFFSET_RST  = 32'd0;
  localparam logic [3:0]  KIND_ENABLES_RST = 4'hF;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TAG    = 3'd0,
    KIND_TEXT   = 3'd1,
    KIND_WORD   = 3'd2,
    KIND_CHAR   = 3'd3,
    KIND_BIGRAM = 3'd4
  } token_kind_t;

  // One token record, start kept as a document byte count
  typedef struct packed {
    token_kind_t kind;
    pos_t        start;
    pos_t        length;
  } rec_t;

  // All records caused by one byte, in output order
  typedef struct packed {
    logic [REC_CNT_W-1:0]   count;
    rec_t [MAX_RECS-1:0]    recs;
  } bundle_t;

  // Configuration seen by front and back
  typedef struct packed {
    logic [31:0] base_offset;
    logic [3:0]  kind_enables;
  } cfg_t;

  // UTF-8 character length from its lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7:4] == 4'hF)      len = 3'd4;
    else if (b[7:5] == 3'h7) len = 3'd3;
    else if (b[7:6] == 2'h3) len = 3'd2;
    else                     len = 3'd1;
    return len;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage

// ===== rtl/hct_front.sv =====
// ============================================================================
// hct_front: byte classifier and record builder
// Accepts one document byte per cycle while the queue is not full, tracks tag/text/word/character state
// and builds the bundle of records that byte closes.
// ============================================================================
module hct_front
  import hct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // doc_end
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        push,
  output bundle_t     push_data
);

  // Document state
  pos_t       position,        position_next;
  logic       inside_tag,      inside_tag_next;
  pos_t       tag_start,       tag_start_next;
  logic       segment_active,  segment_active_next;
  pos_t       segment_start,   segment_start_next;
  logic       word_active,     word_active_next;
  pos_t       word_start,      word_start_next;
  logic       run_active,      run_active_next;
  pos_t       char_start,      char_start_next;
  logic [1:0] char_bytes_left, char_bytes_left_next;
  logic       prev_char_valid, prev_char_valid_next;
  pos_t       prev_char_start, prev_char_start_next;

  logic accept;

  // Candidate records: word, bigram, char, text, tag
  logic        w_v, b_v, c_v, x_v, g_v;
  pos_t        w_s, b_s, c_s, x_s, g_s;
  pos_t        w_e, ce, x_e, g_e;
  logic        slot_v [NUM_SLOTS];
  token_kind_t slot_k [NUM_SLOTS];
  pos_t        slot_s [NUM_SLOTS];
  pos_t        slot_e [NUM_SLOTS];

  pos_t       nxt, seg_start_eff;
  logic       cont;
  logic [2:0] lead_len;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign nxt           = position + pos_t'(1);
  assign seg_start_eff = segment_active ? segment_start : position;
  assign cont          = run_active && (char_bytes_left != 2'd0);
  assign lead_len      = lead_length(s_tdata);

  // Next state and the records this byte closes
  always_comb begin
    position_next        = position;
    inside_tag_next      = inside_tag;
    tag_start_next       = tag_start;
    segment_active_next  = segment_active;
    segment_start_next   = segment_start;
    word_active_next     = word_active;
    word_start_next      = word_start;
    run_active_next      = run_active;
    char_start_next      = char_start;
    char_bytes_left_next = char_bytes_left;
    prev_char_valid_next = prev_char_valid;
    prev_char_start_next = prev_char_start;

    w_v = 1'b0; b_v = 1'b0; c_v = 1'b0; x_v = 1'b0; g_v = 1'b0;
    w_s = word_start;      w_e = position;
    b_s = prev_char_start; c_s = char_start; ce = nxt;
    x_s = seg_start_eff;   x_e = nxt;
    g_s = tag_start;       g_e = nxt;

    if (inside_tag) begin
      if ((s_tdata == CH_GT) || s_tlast) begin
        g_v             = 1'b1;
        inside_tag_next = 1'b0;
      end
    end else if (s_tdata == CH_LT) begin
      // '<' closes everything open in text, cut characters end before it
      w_v = word_active;
      c_v = cont;
      b_v = cont && prev_char_valid;
      ce  = position;
      x_v = segment_active;
      x_s = segment_start;
      x_e = position;
      g_v = s_tlast;
      g_s = position;
      word_active_next     = 1'b0;
      run_active_next      = 1'b0;
      char_bytes_left_next = 2'd0;
      prev_char_valid_next = 1'b0;
      segment_active_next  = 1'b0;
      inside_tag_next      = 1'b1;
      tag_start_next       = position;
    end else begin
      segment_active_next = 1'b1;
      segment_start_next  = seg_start_eff;
      x_v                 = s_tlast;
      if (cont) begin
        // continuation byte of a multi-byte character
        char_bytes_left_next = char_bytes_left - 2'd1;
        c_v = (char_bytes_left == 2'd1) || s_tlast;
        b_v = c_v && prev_char_valid;
        if (char_bytes_left == 2'd1) begin
          prev_char_valid_next = 1'b1;
          prev_char_start_next = char_start;
        end
      end else if (s_tdata[7]) begin
        // lead byte of a character
        w_v                  = word_active;
        word_active_next     = 1'b0;
        run_active_next      = 1'b1;
        char_start_next      = position;
        char_bytes_left_next = 2'(lead_len - 3'd1);
        c_v = (lead_len == 3'd1) || s_tlast;
        c_s = position;
        b_v = c_v && run_active && prev_char_valid;
        if (lead_len == 3'd1) begin
          prev_char_valid_next = 1'b1;
          prev_char_start_next = position;
        end else begin
          prev_char_valid_next = run_active && prev_char_valid;
        end
      end else begin
        // plain ASCII: ends any run, builds or ends a word
        run_active_next      = 1'b0;
        char_bytes_left_next = 2'd0;
        prev_char_valid_next = 1'b0;
        if (is_alnum(s_tdata)) begin
          word_active_next = 1'b1;
          if (!word_active) begin
            word_start_next = position;
          end
          w_v = s_tlast;
          w_s = word_active ? word_start : position;
          w_e = nxt;
        end else begin
          word_active_next = 1'b0;
          w_v              = word_active;
        end
      end
    end

    // end of document returns all state to reset
    if (s_tlast) begin
      position_next        = '0;
      inside_tag_next      = 1'b0;
      tag_start_next       = '0;
      segment_active_next  = 1'b0;
      segment_start_next   = '0;
      word_active_next     = 1'b0;
      word_start_next      = '0;
      run_active_next      = 1'b0;
      char_start_next      = '0;
      char_bytes_left_next = 2'd0;
      prev_char_valid_next = 1'b0;
      prev_char_start_next = '0;
    end else begin
      position_next = nxt;
    end

    // slot table in output order, filtered by the kind enables
    slot_v[0] = w_v && cfg.kind_enables[EN_BIT_WORD];
    slot_k[0] = KIND_WORD;   slot_s[0] = w_s; slot_e[0] = w_e;
    slot_v[1] = b_v && cfg.kind_enables[EN_BIT_CJK];
    slot_k[1] = KIND_BIGRAM; slot_s[1] = b_s; slot_e[1] = ce;
    slot_v[2] = c_v && cfg.kind_enables[EN_BIT_CJK];
    slot_k[2] = KIND_CHAR;   slot_s[2] = c_s; slot_e[2] = ce;
    slot_v[3] = x_v && cfg.kind_enables[EN_BIT_TEXT];
    slot_k[3] = KIND_TEXT;   slot_s[3] = x_s; slot_e[3] = x_e;
    slot_v[4] = g_v && cfg.kind_enables[EN_BIT_TAG];
    slot_k[4] = KIND_TAG;    slot_s[4] = g_s; slot_e[4] = g_e;
  end

  // Pack the live slots into the bundle, first come first
  always_comb begin
    logic [REC_CNT_W-1:0] n;
    n         = '0;
    push_data = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_v[i] && (n < REC_CNT_W'(MAX_RECS))) begin
        push_data.recs[n[REC_IDX_W-1:0]].kind   = slot_k[i];
        push_data.recs[n[REC_IDX_W-1:0]].start  = slot_s[i];
        push_data.recs[n[REC_IDX_W-1:0]].length = slot_e[i] - slot_s[i];
        n = n + REC_CNT_W'(1);
      end
    end
    push_data.count = n;
  end

  assign push = accept && (push_data.count != '0);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      inside_tag      <= 1'b0;
      tag_start       <= '0;
      segment_active  <= 1'b0;
      segment_start   <= '0;
      word_active     <= 1'b0;
      word_start      <= '0;
      run_active      <= 1'b0;
      char_start      <= '0;
      char_bytes_left <= 2'd0;
      prev_char_valid <= 1'b0;
      prev_char_start <= '0;
    end else if (accept) begin
      position        <= position_next;
      inside_tag      <= inside_tag_next;
      tag_start       <= tag_start_next;
      segment_active  <= segment_active_next;
      segment_start   <= segment_start_next;
      word_active     <= word_active_next;
      word_start      <= word_start_next;
      run_active      <= run_active_next;
      char_start      <= char_start_next;
      char_bytes_left <= char_bytes_left_next;
      prev_char_valid <= prev_char_valid_next;
      prev_char_start <= prev_char_start_next;
    end
  end

endmodule

// ===== rtl/hct_queue.sv =====
// ============================================================================
// hct_queue: bundle queue between front and back
// Small register FIFO of per-byte record bundles.
// ============================================================================
module hct_queue
  import hct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  bundle_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/hct_back.sv =====
// ============================================================================
// hct_back: record serialiser
// Walks the head bundle one record per cycle while the output is not stalled, adds the base offset and
// drives the output register.
// ============================================================================
module hct_back
  import hct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  bundle_t              head,
  input  logic                 empty,
  output logic                 pop,
  input  cfg_t                 cfg,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // [2:0] token_kind, [34:3] token_offset,
                                         // [66:35] token_length, rest zero
  output logic                 m_tlast   // last_of_run
);

  logic [REC_IDX_W-1:0] idx;
  logic                 load;
  logic                 last_rec;
  rec_t                 cur;
  pos_t                 offset_sum;

  assign load       = !empty && (!m_tvalid || m_tready);
  assign cur        = head.recs[idx];
  assign last_rec   = (REC_CNT_W'(idx) + REC_CNT_W'(1)) == head.count;
  assign pop        = load && last_rec;
  assign offset_sum = pos_t'(cfg.base_offset) + cur.start;

  // Record index within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last_rec ? '0 : idx + REC_IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(M_TDATA_W - OUT_FIELDS_W)'(0), 32'(cur.length), 32'(offset_sum),
                  cur.kind};
      m_tlast <= last_rec;
    end
  end

endmodule

// ===== rtl/html_cjk_tokenizer.sv =====
// ============================================================================
// html_cjk_tokenizer: streaming HTML tokenizer with CJK bigrams
// Top level: configuration registers, classifier front, queue, serialiser.
// ============================================================================
// The block takes one document byte per clock on the slave stream (tlast marks
// the last byte) and emits token records on the master stream: tags, text
// segments, ASCII words, and UTF-8 characters, each but the first of a run preceded by a bigram with
// the previous character of its run. One byte can close zero to four records;
// they leave one per cycle in order while the receiver is ready, tlast set on
// the last record of a byte. Bytes are accepted every cycle while the
// four-bundle queue between the classifier and the serialiser has room, so
// input runs at one byte per cycle as long as bytes close no more than one
// record each on average and the receiver keeps up; the single output port,
// one record per cycle, bounds sustained throughput. The first record of a
// byte is written into the queue and then into the output register of the
// serialiser, which walks the records of a bundle before popping it.
// Registers: base_offset at 0x0, kind_enables at 0x4 (address bit 2 selects).
module html_cjk_tokenizer
  import hct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // document bytes
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tlast,   // doc_end
  // token records
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] token_kind, [34:3] token_offset,
                                          // [66:35] token_length, rest zero
  output logic                 m_tlast,   // last_of_run
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t    cfg;
  logic    cfg_wr;
  logic    q_push, q_pop, q_empty, q_full;
  bundle_t q_in, q_head;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_offset  <= BASE_OFFSET_RST;
      cfg.kind_enables <= KIND_ENABLES_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BASE_OFFSET:  cfg.base_offset  <= pwdata;
        REG_KIND_ENABLES: cfg.kind_enables <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BASE_OFFSET:  prdata = cfg.base_offset;
      REG_KIND_ENABLES: prdata = {28'd0, cfg.kind_enables};
      default:          prdata = '0;
    endcase
  end

  hct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  hct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  hct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .cfg      (cfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== rtl/hct_checker.sv =====
// ============================================================================
// hct_checker: port-level checks for the tokenizer
// Watches the top-level ports; bound to html_cjk_tokenizer.
// ============================================================================
module hct_checker
  import hct_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output record changed while stalled");

  // nothing leaves straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // kind is a known code
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == KIND_TAG) || (m_tdata[2:0] == KIND_TEXT) ||
                 (m_tdata[2:0] == KIND_WORD) || (m_tdata[2:0] == KIND_CHAR) ||
                 (m_tdata[2:0] == KIND_BIGRAM))
    else $error("unknown token kind");

  // every record covers at least one byte, padding is zero
  a_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[66:35] != 32'd0) && (m_tdata[M_TDATA_W-1:OUT_FIELDS_W] == '0))
    else $error("empty token or dirty padding");

endmodule

bind html_cjk_tokenizer hct_checker u_hct_checker (.*);

// ===== tb/html_cjk_tokenizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// html_cjk_tokenizer_tb: self-checking bench for the HTML/CJK tokenizer
// Feeds documents byte by byte on the slave stream, predicts the token records
// of each accepted byte with a behavioural tokenizer of its own, and compares
// every record on the master stream field by field, in order. Both streams
// idle at random; the register port is written between phases.
// ----------------------------------------------------------------------------
module html_cjk_tokenizer_tb;
  import hct_pkg::*;

  localparam logic [2:0] ADDR_BASE_OFFSET  = 3'd0;
  localparam logic [2:0] ADDR_KIND_ENABLES = 3'd4;
  localparam int IDLE_PCT      = 37;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    token_kind_t kind;
    logic [31:0] offset;
    logic [31:0] length;
    logic        last;
  } token_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [7:0] data_byte
  logic                 s_tlast;   // doc_end
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // [2:0] token_kind, [34:3] token_offset,
                                   // [66:35] token_length, rest zero
  logic                 m_tlast;   // last_of_run
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  html_cjk_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shared bench state
  token_t      pending_tokens[$];
  token_t      byte_tokens[$];
  logic [7:0]  doc_buf[$];
  int unsigned errors = 0;
  bit          steady = 0;
  bit          hold_req = 0;
  bit          hold_ack = 0;
  int unsigned quiet_cycles = 0;

  // Tokenizer state as seen by the bench
  logic [31:0] cfg_base = BASE_OFFSET_RST;
  logic [3:0]  cfg_en   = KIND_ENABLES_RST;
  logic [31:0] doc_pos = 0, tag_from = 0, seg_from = 0, word_from = 0;
  logic [31:0] char_from = 0, prev_from = 0;
  bit          in_tag = 0, in_seg = 0, in_word = 0, in_run = 0, prev_ok = 0;
  int unsigned char_left = 0;

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic bit is_word_byte(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  // Queue one record for the current byte, unless its kind is masked off or the byte already has MAX_RECS
  function automatic void add_token(token_kind_t k, logic [31:0] from, logic [31:0] upto);
    token_t t;
    int     en_bit;
    en_bit = (k == KIND_CHAR || k == KIND_BIGRAM) ? EN_BIT_CJK : int'(k);
    if (!cfg_en[en_bit] || byte_tokens.size() >= MAX_RECS) return;
    t.kind   = k;
    t.offset = cfg_base + from;
    t.length = upto - from;
    t.last   = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void finish_char(logic [31:0] upto);
    if (prev_ok) add_token(KIND_BIGRAM, prev_from, upto);
    add_token(KIND_CHAR, char_from, upto);
    prev_ok   = 1;
    prev_from = char_from;
    char_left = 0;
  endfunction

  function automatic void close_word(logic [31:0] upto);
    if (in_word) add_token(KIND_WORD, word_from, upto);
    in_word = 0;
  endfunction

  function automatic void close_run(logic [31:0] upto);
    if (in_run && char_left > 0) finish_char(upto);
    in_run    = 0;
    char_left = 0;
    prev_ok   = 0;
  endfunction

  function automatic void close_segment(logic [31:0] upto);
    close_word(upto);
    close_run(upto);
    if (in_seg) add_token(KIND_TEXT, seg_from, upto);
    in_seg = 0;
  endfunction

  // Work out the records one accepted byte closes and queue them in order
  function automatic void tokenize_byte(logic [7:0] b, logic last);
    logic [31:0] p;
    logic [31:0] nxt;
    int unsigned span;
    token_t      t;
    p   = doc_pos;
    nxt = p + 32'd1;
    byte_tokens.delete();
    if (in_tag) begin
      if (b == CH_GT || last) begin
        add_token(KIND_TAG, tag_from, nxt);
        in_tag = 0;
      end
    end else if (b == CH_LT) begin
      close_segment(p);
      in_tag   = 1;
      tag_from = p;
      if (last) begin
        add_token(KIND_TAG, p, nxt);
        in_tag = 0;
      end
    end else begin
      if (!in_seg) begin
        in_seg   = 1;
        seg_from = p;
      end
      if (in_run && char_left > 0) begin
        // trailing byte of a character, whatever its value
        char_left--;
        if (char_left == 0) finish_char(nxt);
      end else if (b[7]) begin
        close_word(p);
        if (!in_run) begin
          in_run  = 1;
          prev_ok = 0;
        end
        char_from = p;
        casez (b)
          8'b1111????: span = 4;
          8'b1110????: span = 3;
          8'b110?????: span = 2;
          default:     span = 1;
        endcase
        char_left = span - 1;
        if (char_left == 0) finish_char(nxt);
      end else begin
        close_run(p);
        if (is_word_byte(b)) begin
          if (!in_word) begin
            in_word   = 1;
            word_from = p;
          end
        end else begin
          close_word(p);
        end
      end
      if (last) close_segment(nxt);
    end
    // end of document: everything but the registers goes back to reset
    if (last) begin
      doc_pos = 0; tag_from = 0; seg_from = 0; word_from = 0;
      char_from = 0; prev_from = 0; char_left = 0;
      in_tag = 0; in_seg = 0; in_word = 0; in_run = 0; prev_ok = 0;
    end else begin
      doc_pos = nxt;
    end
    foreach (byte_tokens[i]) begin
      t      = byte_tokens[i];
      t.last = (i == byte_tokens.size() - 1);
      pending_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Record checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token record: tdata %h tlast %b", m_tdata, m_tlast);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        if (m_tdata[2:0] !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[34:3] !== want.offset) begin
          $error("token_offset: expected %h, got %h", want.offset, m_tdata[34:3]);
          errors++;
        end
        if (m_tdata[66:35] !== want.length) begin
          $error("token_length: expected %0d, got %0d", want.length, m_tdata[66:35]);
          errors++;
        end
        if (m_tdata[M_TDATA_W-1:67] !== '0) begin
          $error("tdata padding: expected 0, got %h", m_tdata[M_TDATA_W-1:67]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_ack = hold_req;
      end
      m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one byte, wait for the handshake, then maybe leave a gap
  task automatic send_byte(logic [7:0] b, logic last);
    s_tdata  = b;
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    tokenize_byte(b, last);
    @(negedge clk);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic send_doc();
    foreach (doc_buf[i]) send_byte(doc_buf[i], i == doc_buf.size() - 1);
  endtask

  // Stop offering and wait for every expected record, then let the pipe settle
  task automatic wait_drain();
    s_tvalid = 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a read-back
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_BASE_OFFSET) cfg_base = value;
    else                          cfg_en   = value[3:0];
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("register %0d read-back: expected %h, got %h", addr, value, prdata);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Random document built from plausible fragments with some noise mixed in
  task automatic build_doc(int unsigned n);
    int unsigned k;
    int unsigned span;
    logic [7:0]  b;
    doc_buf.delete();
    while (doc_buf.size() < n) begin
      case ($urandom_range(9))
        0, 1, 8: begin
          // ASCII word
          repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(2))
              0:       b = 8'(8'h30 + $urandom_range(9));
              1:       b = 8'(8'h41 + $urandom_range(25));
              default: b = 8'(8'h61 + $urandom_range(25));
            endcase
            doc_buf.push_back(b);
          end
        end
        2: begin
          // punctuation or white space
          do b = 8'($urandom_range(1, 127)); while (is_word_byte(b) || b == CH_LT);
          doc_buf.push_back(b);
        end
        3, 4, 9: begin
          // UTF-8 character, lead byte picks the length
          span = $urandom_range(1, 4);
          case (span)
            1:       b = 8'($urandom_range(8'h80, 8'hBF));
            2:       b = 8'($urandom_range(8'hC0, 8'hDF));
            3:       b = 8'($urandom_range(8'hE0, 8'hEF));
            default: b = 8'($urandom_range(8'hF0, 8'hFF));
          endcase
          doc_buf.push_back(b);
          for (k = 1; k < span; k++) begin
            if ($urandom_range(9) == 0) b = 8'($urandom_range(1, 255));
            else                        b = 8'($urandom_range(8'h80, 8'hBF));
            doc_buf.push_back(b);
          end
        end
        5: begin
          // tag with random body
          doc_buf.push_back(CH_LT);
          repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_GT);
            doc_buf.push_back(b);
          end
          doc_buf.push_back(CH_GT);
        end
        6: doc_buf.push_back(CH_GT);
        default: doc_buf.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    while (doc_buf.size() > n) void'(doc_buf.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every kind, stray '>', byte extremes, a character cut by '<' and one cut
  // by the end of the document
  task automatic test_directed_doc();
    doc_buf = '{"w", "1", ">", 8'hE4, 8'hB8, 8'hAD, 8'hC3, 8'hA9, 8'h80,
                8'hE6, 8'h96, "<", "b", ">", 8'h01, 8'hFF, 8'h9F};
    send_doc();
    wait_drain();
  endtask

  // Tag still open when the document ends
  task automatic test_unclosed_tag();
    doc_buf = '{"<", "a"};
    send_doc();
    wait_drain();
  endtask

  // base_offset changed halfway through a document, offsets wrap
  task automatic test_mid_doc_base();
    send_byte("x", 1'b0);
    send_byte("y", 1'b0);
    send_byte(" ", 1'b0);
    wait_drain();
    write_reg(ADDR_BASE_OFFSET, 32'hFFFF_FFFE);
    send_byte("q", 1'b0);
    send_byte("r", 1'b1);
    wait_drain();
  endtask

  // Kind masks and offset extremes
  task automatic test_enable_masks();
    logic [3:0]  masks [4];
    logic [31:0] bases [4];
    masks = '{4'h0, 4'h5, 4'hA, 4'(($urandom_range(1, 14)))};
    bases = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFF0, $urandom};
    foreach (masks[i]) begin
      write_reg(ADDR_KIND_ENABLES, {28'd0, masks[i]});
      write_reg(ADDR_BASE_OFFSET, bases[i]);
      build_doc(8);
      send_doc();
      wait_drain();
    end
    write_reg(ADDR_KIND_ENABLES, {28'd0, KIND_ENABLES_RST});
  endtask

  // Random documents, the middle one with no idling on either side
  task automatic test_random_docs();
    write_reg(ADDR_BASE_OFFSET, $urandom);
    for (int i = 0; i < 3; i++) begin
      steady = (i == 1);
      build_doc($urandom_range(8, 16));
      send_doc();
      wait_drain();
    end
    steady = 0;
  endtask

  // Receiver holds off while bytes keep coming, so the input must stall
  task automatic test_backpressure();
    write_reg(ADDR_BASE_OFFSET, 32'd0);
    build_doc(24);
    hold_req = ~hold_req;
    send_doc();
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 3'd0;
    pwdata   = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed_doc();
    test_unclosed_tag();
    test_mid_doc_base();
    test_enable_masks();
    test_random_docs();
    test_backpressure();

    wait_drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
